@@ rtl/nnta_pkg.sv @@
// Shared types and constants for the nearest-neighbor track association block.
// Used by nnta_ctrl, nnta_datapath and nearest_neighbor_track_association_core.
// No dependencies.
package nnta_pkg;

    // Track table size and derived index width
    localparam int MAX_TRACKS = 32;
    localparam int SLOT_W     = $clog2(MAX_TRACKS);

    // Field widths
    localparam int COORD_W = 16;
    localparam int IDENT_W = 16;
    localparam int AGE_W   = 16;
    localparam int LOST_W  = 6;
    localparam int CNT_W   = 6;
    localparam int GATE_W  = 16;
    localparam int CFG_W   = 16;
    localparam int SQ_W    = 2 * COORD_W;
    localparam int DIST_W  = SQ_W + 1 - 8;

    // Saturation limits and register reset values
    localparam logic [AGE_W-1:0]  AGE_MAX        = '1;
    localparam logic [LOST_W-1:0] LOST_MAX       = '1;
    localparam logic [GATE_W-1:0] GATE_RESET     = GATE_W'(15 * 15);
    localparam logic [LOST_W-1:0] LOST_LIM_RESET = LOST_W'(50);

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_GATE_DIST_SQ = 1'b0,
        CFG_LOST_LIMIT   = 1'b1
    } cfg_index_t;

    // Operation codes
    localparam logic OP_CENTER = 1'b0;
    localparam logic OP_EOF    = 1'b1;

    typedef struct packed {
        logic               operation;
        logic [COORD_W-1:0] center_x;
        logic [COORD_W-1:0] center_y;
    } in_item_t;

    typedef struct packed {
        logic [IDENT_W-1:0] track_number;
        logic               is_new;
        logic               dropped;
        logic [AGE_W-1:0]   track_age;
        logic [CNT_W-1:0]   live_count;
        logic [CNT_W-1:0]   removed_count;
    } out_item_t;

    // One entry of the track table memory
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [IDENT_W-1:0] ident;
        logic [LOST_W-1:0]  lost;
        logic [AGE_W-1:0]   age;
    } slot_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT,
        ST_DONE
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic              load;
        logic              issue;
        logic              commit;
        logic [SLOT_W-1:0] addr;
    } ctl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic pipe_busy;
    } dp_status_t;

endpackage

@@ rtl/nnta_ctrl.sv @@
// Controller state machine: sequences the slot scan, drain, commit and result.
// Depends on nnta_pkg.
module nnta_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  nnta_pkg::dp_status_t status,
    output logic                busy,
    output logic                done,
    output nnta_pkg::ctl_cmd_t  cmd
);

    nnta_pkg::state_t               state_reg;
    nnta_pkg::state_t               state_next;
    logic [nnta_pkg::SLOT_W-1:0]    cnt_reg;
    logic [nnta_pkg::SLOT_W-1:0]    cnt_next;
    logic                           scan_last;

    assign scan_last = (cnt_reg == nnta_pkg::SLOT_W'(nnta_pkg::MAX_TRACKS - 1));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            nnta_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = nnta_pkg::ST_SCAN;
                end
            end
            nnta_pkg::ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = nnta_pkg::ST_DRAIN;
                end
            end
            nnta_pkg::ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = nnta_pkg::ST_COMMIT;
                end
            end
            nnta_pkg::ST_COMMIT:
            begin
                state_next = nnta_pkg::ST_DONE;
            end
            nnta_pkg::ST_DONE:
            begin
                state_next = nnta_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = nnta_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs and scan counter
    always_comb
    begin
        busy       = 1'b1;
        done       = 1'b0;
        cmd.load   = 1'b0;
        cmd.issue  = 1'b0;
        cmd.commit = 1'b0;
        cmd.addr   = cnt_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            nnta_pkg::ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
                cnt_next = '0;
            end
            nnta_pkg::ST_SCAN:
            begin
                cmd.issue = 1'b1;
                cnt_next  = cnt_reg + 1'b1;
            end
            nnta_pkg::ST_DRAIN:
            begin
                cnt_next = '0;
            end
            nnta_pkg::ST_COMMIT:
            begin
                cmd.commit = 1'b1;
            end
            nnta_pkg::ST_DONE:
            begin
                done = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nnta_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

@@ rtl/nnta_datapath.sv @@
// Datapath: track table memory, distance pipeline, best-match search and commit.
// Depends on nnta_pkg; driven by nnta_ctrl commands.
module nnta_datapath
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  nnta_pkg::ctl_cmd_t                cmd,
    input  nnta_pkg::in_item_t                item,
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [nnta_pkg::CFG_W-1:0]        cfg_data,
    output nnta_pkg::dp_status_t              status,
    output nnta_pkg::out_item_t               result
);

    localparam int SLOT_W  = nnta_pkg::SLOT_W;
    localparam int NSLOT   = nnta_pkg::MAX_TRACKS;
    localparam int COORD_W = nnta_pkg::COORD_W;
    localparam int IDENT_W = nnta_pkg::IDENT_W;
    localparam int AGE_W   = nnta_pkg::AGE_W;
    localparam int LOST_W  = nnta_pkg::LOST_W;
    localparam int CNT_W   = nnta_pkg::CNT_W;
    localparam int SQ_W    = nnta_pkg::SQ_W;
    localparam int DIST_W  = nnta_pkg::DIST_W;

    // Configuration registers
    logic [nnta_pkg::GATE_W-1:0] gate_reg;
    logic [LOST_W-1:0]           lost_limit_reg;

    // Latched item
    logic               op_reg;
    logic [COORD_W-1:0] cx_reg;
    logic [COORD_W-1:0] cy_reg;

    // Per-slot flags
    logic [NSLOT-1:0]   valid_reg;
    logic [NSLOT-1:0]   valid_next;
    logic [NSLOT-1:0]   hit_reg;
    logic [NSLOT-1:0]   hit_next;
    logic [IDENT_W-1:0] next_ident_reg;
    logic [IDENT_W-1:0] next_ident_next;

    // Track table memory
    nnta_pkg::slot_word_t slot_mem [NSLOT];
    nnta_pkg::slot_word_t rd_word_reg;
    logic                 mem_we;
    logic [SLOT_W-1:0]    mem_waddr;
    nnta_pkg::slot_word_t mem_wdata;

    // Stage 1: read data
    logic              s1_v_reg;
    logic [SLOT_W-1:0] s1_idx_reg;

    // Stage 2: absolute differences
    logic               s2_v_reg;
    logic [SLOT_W-1:0]  s2_idx_reg;
    logic [COORD_W-1:0] dx_reg;
    logic [COORD_W-1:0] dy_reg;
    logic [IDENT_W-1:0] s2_ident_reg;
    logic [LOST_W-1:0]  s2_lost_reg;
    logic [AGE_W-1:0]   s2_age_reg;

    // Stage 3: squares
    logic               s3_v_reg;
    logic [SLOT_W-1:0]  s3_idx_reg;
    logic [SQ_W-1:0]    sqx_reg;
    logic [SQ_W-1:0]    sqy_reg;
    logic [IDENT_W-1:0] s3_ident_reg;
    logic [LOST_W-1:0]  s3_lost_reg;
    logic [AGE_W-1:0]   s3_age_reg;

    // Stage 4: distance, gate and age key
    logic               s4_v_reg;
    logic [SLOT_W-1:0]  s4_idx_reg;
    logic [DIST_W-1:0]  dist_reg;
    logic               in_gate_reg;
    logic [IDENT_W-1:0] old_reg;
    logic [IDENT_W-1:0] s4_ident_reg;
    logic [LOST_W-1:0]  s4_lost_reg;
    logic [AGE_W-1:0]   s4_age_reg;

    // Best match and first free slot
    logic               best_found_reg;
    logic [SLOT_W-1:0]  best_idx_reg;
    logic [DIST_W-1:0]  best_dist_reg;
    logic [IDENT_W-1:0] best_old_reg;
    logic [IDENT_W-1:0] best_ident_reg;
    logic [LOST_W-1:0]  best_lost_reg;
    logic [AGE_W-1:0]   best_age_reg;
    logic               free_found_reg;
    logic [SLOT_W-1:0]  free_idx_reg;

    // End-of-frame counters
    logic [CNT_W-1:0] live_cnt_reg;
    logic [CNT_W-1:0] removed_cnt_reg;

    nnta_pkg::out_item_t result_reg;
    nnta_pkg::out_item_t result_next;

    // Stage 1 decode
    logic              s1_valid_slot;
    logic              s1_center;
    logic              eof_v;
    logic              eof_unhit;
    logic [LOST_W-1:0] lost_inc;
    logic              eof_remove;

    // Distance and best compare
    logic [SQ_W:0]      sq_sum;
    logic [DIST_W-1:0]  dist_w;
    logic               take;
    logic [AGE_W-1:0]   best_age_inc;
    logic [IDENT_W-1:0] new_ident;

    assign status.pipe_busy = s1_v_reg | s2_v_reg | s3_v_reg | s4_v_reg;
    assign result           = result_reg;

    assign s1_valid_slot = valid_reg[s1_idx_reg];
    assign s1_center     = s1_v_reg && (op_reg == nnta_pkg::OP_CENTER);
    assign eof_v         = s1_v_reg && (op_reg == nnta_pkg::OP_EOF) && s1_valid_slot;
    assign eof_unhit     = !hit_reg[s1_idx_reg];
    assign lost_inc      = (rd_word_reg.lost == nnta_pkg::LOST_MAX) ? rd_word_reg.lost
                                                                    : rd_word_reg.lost + 1'b1;
    assign eof_remove    = eof_unhit && (lost_inc > lost_limit_reg);

    assign sq_sum = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign dist_w = sq_sum[SQ_W:8];

    assign take = s4_v_reg && in_gate_reg
                  && (!best_found_reg || (dist_reg < best_dist_reg)
                      || ((dist_reg == best_dist_reg) && (old_reg > best_old_reg)));

    assign best_age_inc = (best_age_reg == nnta_pkg::AGE_MAX) ? best_age_reg
                                                              : best_age_reg + 1'b1;
    assign new_ident    = next_ident_reg + 1'b1;

    // Memory write select, slot flags and result
    always_comb
    begin
        mem_we          = 1'b0;
        mem_waddr       = s1_idx_reg;
        mem_wdata       = rd_word_reg;
        valid_next      = valid_reg;
        hit_next        = hit_reg;
        next_ident_next = next_ident_reg;
        result_next     = '0;

        // Advance lost count during the end-of-frame sweep
        if (eof_v && eof_unhit)
        begin
            mem_we         = 1'b1;
            mem_wdata.lost = lost_inc;
            if (eof_remove)
            begin
                valid_next[s1_idx_reg] = 1'b0;
            end
        end

        if (cmd.commit)
        begin
            if (op_reg == nnta_pkg::OP_EOF)
            begin
                hit_next                  = '0;
                result_next.live_count    = live_cnt_reg;
                result_next.removed_count = removed_cnt_reg;
            end
            else if (best_found_reg)
            begin
                mem_we                   = 1'b1;
                mem_waddr                = best_idx_reg;
                mem_wdata.x              = cx_reg;
                mem_wdata.y              = cy_reg;
                mem_wdata.ident          = best_ident_reg;
                mem_wdata.lost           = best_lost_reg;
                mem_wdata.age            = best_age_inc;
                hit_next[best_idx_reg]   = 1'b1;
                result_next.track_number = best_ident_reg;
                result_next.track_age    = best_age_inc;
            end
            else if (free_found_reg)
            begin
                mem_we                   = 1'b1;
                mem_waddr                = free_idx_reg;
                mem_wdata.x              = cx_reg;
                mem_wdata.y              = cy_reg;
                mem_wdata.ident          = new_ident;
                mem_wdata.lost           = '0;
                mem_wdata.age            = '0;
                valid_next[free_idx_reg] = 1'b1;
                hit_next[free_idx_reg]   = 1'b1;
                next_ident_next          = new_ident;
                result_next.track_number = new_ident;
                result_next.is_new       = 1'b1;
            end
            else
            begin
                result_next.dropped = 1'b1;
            end
        end
    end

    // Track table memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        rd_word_reg <= slot_mem[cmd.addr];
    end

    // Configuration, flags and pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gate_reg        <= nnta_pkg::GATE_RESET;
            lost_limit_reg  <= nnta_pkg::LOST_LIM_RESET;
            valid_reg       <= '0;
            hit_reg         <= '0;
            next_ident_reg  <= '0;
            s1_v_reg        <= 1'b0;
            s2_v_reg        <= 1'b0;
            s3_v_reg        <= 1'b0;
            s4_v_reg        <= 1'b0;
            best_found_reg  <= 1'b0;
            free_found_reg  <= 1'b0;
            live_cnt_reg    <= '0;
            removed_cnt_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    nnta_pkg::CFG_GATE_DIST_SQ: gate_reg       <= cfg_data;
                    nnta_pkg::CFG_LOST_LIMIT:   lost_limit_reg <= cfg_data[LOST_W-1:0];
                    default:                    gate_reg       <= gate_reg;
                endcase
            end

            valid_reg      <= valid_next;
            hit_reg        <= hit_next;
            next_ident_reg <= next_ident_next;

            s1_v_reg <= cmd.issue;
            s2_v_reg <= s1_center && s1_valid_slot;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg;

            // Clear search state on a new transaction
            if (cmd.load)
            begin
                best_found_reg  <= 1'b0;
                free_found_reg  <= 1'b0;
                live_cnt_reg    <= '0;
                removed_cnt_reg <= '0;
            end
            else
            begin
                if (take)
                begin
                    best_found_reg <= 1'b1;
                end
                if (s1_center && !s1_valid_slot && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                end
                if (eof_v && eof_remove)
                begin
                    removed_cnt_reg <= removed_cnt_reg + 1'b1;
                end
                if (eof_v && !eof_remove)
                begin
                    live_cnt_reg <= live_cnt_reg + 1'b1;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        // Latch the accepted item
        if (cmd.load)
        begin
            op_reg <= item.operation;
            cx_reg <= item.center_x;
            cy_reg <= item.center_y;
        end

        s1_idx_reg <= cmd.addr;

        // Take absolute differences
        s2_idx_reg   <= s1_idx_reg;
        dx_reg       <= (rd_word_reg.x > cx_reg) ? rd_word_reg.x - cx_reg
                                                 : cx_reg - rd_word_reg.x;
        dy_reg       <= (rd_word_reg.y > cy_reg) ? rd_word_reg.y - cy_reg
                                                 : cy_reg - rd_word_reg.y;
        s2_ident_reg <= rd_word_reg.ident;
        s2_lost_reg  <= rd_word_reg.lost;
        s2_age_reg   <= rd_word_reg.age;

        // Square
        s3_idx_reg   <= s2_idx_reg;
        sqx_reg      <= dx_reg * dx_reg;
        sqy_reg      <= dy_reg * dy_reg;
        s3_ident_reg <= s2_ident_reg;
        s3_lost_reg  <= s2_lost_reg;
        s3_age_reg   <= s2_age_reg;

        // Sum, truncate to whole pixels squared, gate
        s4_idx_reg   <= s3_idx_reg;
        dist_reg     <= dist_w;
        in_gate_reg  <= (dist_w <= DIST_W'(gate_reg));
        old_reg      <= next_ident_reg - s3_ident_reg;
        s4_ident_reg <= s3_ident_reg;
        s4_lost_reg  <= s3_lost_reg;
        s4_age_reg   <= s3_age_reg;

        // Keep the nearest, older track on a tie
        if (take)
        begin
            best_idx_reg   <= s4_idx_reg;
            best_dist_reg  <= dist_reg;
            best_old_reg   <= old_reg;
            best_ident_reg <= s4_ident_reg;
            best_lost_reg  <= s4_lost_reg;
            best_age_reg   <= s4_age_reg;
        end

        // Remember the lowest free slot
        if (s1_center && !s1_valid_slot && !free_found_reg)
        begin
            free_idx_reg <= s1_idx_reg;
        end

        if (cmd.commit)
        begin
            result_reg <= result_next;
        end
    end

endmodule

@@ rtl/nearest_neighbor_track_association_core.sv @@
// Top level of the nearest-neighbor track association block.
// Depends on nnta_pkg, nnta_ctrl and nnta_datapath.
//
// Usage:
//   Command channel: drive item and raise start; the transaction is taken at a
//   clock edge with start high and busy low. item.operation selects a cluster
//   center (associate with the nearest gated track, or open a new one) or end
//   of frame (raise lost counts, retire unmatched tracks, clear matched marks).
//   Result channel: result is presented for exactly one cycle with done high;
//   the receiver cannot stall, so it must capture result in that cycle.
//   Configuration: cfg_valid/cfg_ready write channel, cfg_index 0 is the gate
//   (squared pixel distance), 1 is the lost limit. cfg_ready is always high;
//   write only while busy is low.
//   Sequence: the track table is a single-read-port memory, so the scan reads
//   one slot per cycle, then the four-stage distance pipeline drains, the
//   winner is written back and the result is shown. busy stays high until done
//   has been shown, so one transaction is in flight at a time: a new item is
//   not taken before the last one is through.
//   Reset: all tracks dropped, id counter cleared, gate 225, lost limit 50.
module nearest_neighbor_track_association_core
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  nnta_pkg::in_item_t             item,
    output logic                           done,
    output nnta_pkg::out_item_t            result,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic                           cfg_index,
    input  logic [nnta_pkg::CFG_W-1:0]     cfg_data
);

    nnta_pkg::ctl_cmd_t   cmd;
    nnta_pkg::dp_status_t status;
    logic                 cfg_we;

    // Accept configuration writes in any cycle
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid & cfg_ready;

    nnta_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .busy   (busy),
        .done   (done),
        .cmd    (cmd)
    );

    nnta_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .status    (status),
        .result    (result)
    );

endmodule
